@@ hw/rtl/tca_pkg.sv @@
// tca_pkg: shared types, codes and constants of the cursor and auto-wrap engine
// used by every module under hw/rtl; depends on nothing else
package tca_pkg;

    localparam int MAX_COLS = 256;
    localparam int MAX_ROWS = 128;
    localparam int TAB_STOP = 8;

    localparam logic [20:0] CP_BS    = 21'h08;
    localparam logic [20:0] CP_TAB   = 21'h09;
    localparam logic [20:0] CP_LF    = 21'h0A;
    localparam logic [20:0] CP_CR    = 21'h0D;
    localparam logic [20:0] CP_SPACE = 21'h20;
    localparam logic [20:0] CP_DEL   = 21'h7F;

    localparam logic [8:0] COLUMNS_RESET   = 9'd80;
    localparam logic [7:0] ROWS_RESET      = 8'd24;
    localparam logic [6:0] TOP_RESET       = 7'd0;
    localparam logic [7:0] BOTTOM_RESET    = 8'hFF;

    typedef enum logic [1:0] {
        ACT_GLYPH  = 2'd0,
        ACT_SPACER = 2'd1,
        ACT_REGION = 2'd2,
        ACT_SCREEN = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        CFG_COLUMNS = 2'd0,
        CFG_ROWS    = 2'd1,
        CFG_TOP     = 2'd2,
        CFG_BOTTOM  = 2'd3
    } cfg_index_t;

    // derived screen geometry after clamping
    typedef struct packed {
        logic [8:0] cols;
        logic [7:0] rows;
        logic [6:0] bot;
        logic [6:0] shift_top;
        logic       full;
    } geom_t;

    typedef struct packed {
        logic [7:0]  attrs;
        logic [31:0] back;
        logic [31:0] fore;
        logic [1:0]  width;
        logic [20:0] code;
    } item_t;

    typedef struct packed {
        logic [6:0] row;
        logic [7:0] col;
        logic       wrap;
    } cursor_t;

    // slots: 0 line-feed or soft-wrap scroll, 1 wide-wrap scroll, 2 glyph, 3 spacer
    typedef struct packed {
        logic [3:0]  mask;
        action_t     scroll_act;
        logic [6:0]  shift_top;
        logic [6:0]  shift_bottom;
        logic [6:0]  row;
        logic [7:0]  col;
        logic [20:0] code;
        logic [31:0] fore;
        logic [31:0] back;
        logic [7:0]  attrs;
    } bundle_t;

endpackage

@@ hw/rtl/tca_config.sv @@
// tca_config: configuration registers and clamped screen geometry
// depends on tca_pkg
module tca_config (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [8:0]         cfg_data,
    output tca_pkg::geom_t     geom
);
    import tca_pkg::*;

    logic [8:0] columns_reg;
    logic [7:0] rows_reg;
    logic [6:0] top_reg;
    logic [7:0] bottom_reg;

    logic [8:0] cols;
    logic [7:0] rows;
    logic [7:0] last_row;
    logic [6:0] bot;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            columns_reg <= COLUMNS_RESET;
            rows_reg    <= ROWS_RESET;
            top_reg     <= TOP_RESET;
            bottom_reg  <= BOTTOM_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index_t'(cfg_index))
                CFG_COLUMNS: columns_reg <= cfg_data;
                CFG_ROWS:    rows_reg    <= cfg_data[7:0];
                CFG_TOP:     top_reg     <= cfg_data[6:0];
                CFG_BOTTOM:  bottom_reg  <= cfg_data[7:0];
                default:     columns_reg <= columns_reg;
            endcase
        end
    end

    always_comb begin
        cols = columns_reg;
        if (cols == 9'd0) cols = 9'd1;
        if (cols > 9'(MAX_COLS)) cols = 9'(MAX_COLS);
        rows = rows_reg;
        if (rows == 8'd0) rows = 8'd1;
        if (rows > 8'(MAX_ROWS)) rows = 8'(MAX_ROWS);
        last_row = rows - 8'd1;
        // negative bottom means last row; beyond the screen clamps
        if (bottom_reg[7] || bottom_reg > last_row) bot = last_row[6:0];
        else bot = bottom_reg[6:0];
        if (bot < top_reg) bot = last_row[6:0];
        geom.cols      = cols;
        geom.rows      = rows;
        geom.bot       = bot;
        geom.shift_top = (top_reg < bot) ? top_reg : bot;
        geom.full      = (top_reg == 7'd0) && (bot == last_row[6:0]);
    end

endmodule

@@ hw/rtl/tca_step.sv @@
// tca_step: next cursor state and the result slots for one character
// depends on tca_pkg
module tca_step (
    input  tca_pkg::item_t   item,
    input  tca_pkg::cursor_t cur,
    input  tca_pkg::geom_t   geom,
    output tca_pkg::cursor_t nxt,
    output tca_pkg::bundle_t res
);
    import tca_pkg::*;

    logic [1:0] w;
    logic [6:0] row;
    logic [7:0] col;
    logic       wrap;
    logic [3:0] mask;
    logic [8:0] tab_col;
    logic [8:0] col_ext;
    logic [7:0] cell_col;

    // line feed: true when the region bottom is passed
    function automatic logic lf_scroll(input logic [6:0] r, input logic [6:0] b);
        return ({1'b0, r} + 8'd1) > {1'b0, b};
    endfunction

    function automatic logic [6:0] lf_row(input logic [6:0] r, input logic [6:0] b);
        logic [7:0] n;
        n = {1'b0, r} + 8'd1;
        return (n > {1'b0, b}) ? b : n[6:0];
    endfunction

    always_comb begin
        w = (item.width == 2'd3) ? 2'd2 : item.width;
        row = cur.row;
        col = cur.col;
        wrap = cur.wrap;
        mask = 4'b0000;
        tab_col = 9'd0;
        col_ext = 9'd0;
        cell_col = 8'd0;
        if (item.code == CP_LF) begin
            col = 8'd0;
            wrap = 1'b0;
            mask[0] = lf_scroll(row, geom.bot);
            row = lf_row(row, geom.bot);
        end else if (item.code == CP_CR) begin
            col = 8'd0;
            wrap = 1'b0;
        end else if (item.code == CP_BS) begin
            if (wrap) wrap = 1'b0;
            else if (col != 8'd0) col = col - 8'd1;
        end else if (item.code == CP_TAB) begin
            wrap = 1'b0;
            tab_col = ({1'b0, col} & ~9'(TAB_STOP - 1)) + 9'(TAB_STOP);
            if (tab_col >= geom.cols) tab_col = geom.cols - 9'd1;
            col = tab_col[7:0];
        end else if (item.code < CP_SPACE || item.code == CP_DEL) begin
            col = cur.col;
        end else begin
            if (wrap) begin
                col = 8'd0;
                mask[0] = lf_scroll(row, geom.bot);
                row = lf_row(row, geom.bot);
                wrap = 1'b0;
            end
            if (w != 2'd0) begin
                // a wide glyph never straddles the right edge
                if (w == 2'd2 && {1'b0, col} == geom.cols - 9'd1) begin
                    col = 8'd0;
                    mask[1] = lf_scroll(row, geom.bot);
                    row = lf_row(row, geom.bot);
                end
                if ({1'b0, row} < geom.rows && {1'b0, col} < geom.cols) begin
                    mask[2] = 1'b1;
                    mask[3] = (w == 2'd2) && ({1'b0, col} + 9'd1 < geom.cols);
                end
                col_ext = {1'b0, col} + {7'd0, w};
                cell_col = col;
                if (col_ext >= geom.cols) wrap = 1'b1;
                else col = col_ext[7:0];
            end
        end

        res.mask         = mask;
        res.scroll_act   = geom.full ? ACT_SCREEN : ACT_REGION;
        res.shift_top    = geom.full ? 7'd0 : geom.shift_top;
        res.shift_bottom = geom.bot;
        res.row          = row;
        res.col          = cell_col;
        res.code         = item.code;
        res.fore         = item.fore;
        res.back         = item.back;
        res.attrs        = item.attrs;
        nxt.row  = row;
        nxt.col  = col;
        nxt.wrap = wrap;
    end

endmodule

@@ hw/rtl/tca_out_buf.sv @@
// tca_out_buf: holds the result slots of one character and sends them in order
// depends on tca_pkg
module tca_out_buf (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  tca_pkg::bundle_t  res,
    output logic              can_load,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [127:0]      m_tdata,   // row, col, code, fore, back, attrs, shift_top, shift_bottom
    output logic [1:0]        m_tuser,   // action
    output logic              m_tlast
);
    import tca_pkg::*;

    logic [3:0]  mask_reg;
    bundle_t     data_reg;
    logic [3:0]  low_bit;
    logic [3:0]  rest;
    logic        pop;
    logic [6:0]  o_row;
    logic [7:0]  o_col;
    logic [20:0] o_code;
    logic [31:0] o_fore;
    logic [31:0] o_back;
    logic [7:0]  o_attrs;
    logic [6:0]  o_top;
    logic [6:0]  o_bottom;
    action_t     o_act;

    assign low_bit  = mask_reg & (~mask_reg + 4'd1);
    assign rest     = mask_reg & ~low_bit;
    assign m_tvalid = (mask_reg != 4'd0);
    assign m_tlast  = (rest == 4'd0);
    assign pop      = m_tvalid && m_tready;
    assign can_load = !m_tvalid || (pop && m_tlast);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= 4'd0;
        end else if (load) begin
            mask_reg <= res.mask;
        end else if (pop) begin
            mask_reg <= rest;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res;
        end
    end

    always_comb begin
        o_act    = ACT_GLYPH;
        o_row    = 7'd0;
        o_col    = 8'd0;
        o_code   = 21'd0;
        o_fore   = 32'd0;
        o_back   = 32'd0;
        o_attrs  = 8'd0;
        o_top    = 7'd0;
        o_bottom = 7'd0;
        case (low_bit)
            4'b0001, 4'b0010: begin
                o_act    = data_reg.scroll_act;
                o_top    = data_reg.shift_top;
                o_bottom = data_reg.shift_bottom;
            end
            4'b0100, 4'b1000: begin
                o_act   = low_bit[3] ? ACT_SPACER : ACT_GLYPH;
                o_row   = data_reg.row;
                o_col   = data_reg.col + {7'd0, low_bit[3]};
                o_code  = low_bit[3] ? 21'd0 : data_reg.code;
                o_fore  = data_reg.fore;
                o_back  = data_reg.back;
                o_attrs = data_reg.attrs;
            end
            default: o_act = ACT_GLYPH;
        endcase
    end

    assign m_tuser = o_act;
    assign m_tdata = {6'd0, o_bottom, o_top, o_attrs, o_back, o_fore, o_code, o_col, o_row};

endmodule

@@ hw/rtl/terminal_cursor_autowrap_top.sv @@
// terminal_cursor_autowrap_top: cursor and auto-wrap engine with scroll region
// an accepted word is held in the input register, then in the result slot buffer
// throughput: one word per cycle while m_tready is high and no character has more
// than one result; the input register and the result slot buffer part the two sides
// reset: synchronous active-low aresetn clears the cursor, the wrap flag and both
// valid flags, and restores the register defaults; depends on tca_pkg and submodules
module terminal_cursor_autowrap_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // code_point, glyph_width, fore_colour, back_colour, attr_bits
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // cell_row, cell_col, cell_code, cell_fore, cell_back,
                                    // cell_attrs, shift_top, shift_bottom
    output logic [1:0]   m_tuser,   // action
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [8:0]   cfg_data
);
    import tca_pkg::*;

    logic     in_valid_reg;
    item_t    item_reg;
    cursor_t  cursor_reg;
    cursor_t  cursor_next;
    geom_t    geom;
    bundle_t  res;
    logic     can_load;
    logic     xfer;

    assign xfer     = in_valid_reg && can_load;
    assign s_tready = !in_valid_reg || can_load;

    tca_config u_config (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .geom      (geom)
    );

    tca_step u_step (
        .item (item_reg),
        .cur  (cursor_reg),
        .geom (geom),
        .nxt  (cursor_next),
        .res  (res)
    );

    tca_out_buf u_out_buf (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (xfer),
        .res      (res),
        .can_load (can_load),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            cursor_reg   <= '0;
        end else begin
            if (s_tvalid && s_tready) in_valid_reg <= 1'b1;
            else if (xfer) in_valid_reg <= 1'b0;
            if (xfer) cursor_reg <= cursor_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.code  <= s_tdata[20:0];
            item_reg.width <= s_tdata[22:21];
            item_reg.fore  <= s_tdata[54:23];
            item_reg.back  <= s_tdata[86:55];
            item_reg.attrs <= s_tdata[94:87];
        end
    end

    // a held word is never dropped while the result buffer is busy
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !can_load |=> in_valid_reg)
        else $error("input word lost while result buffer busy");

    // taking a new word while one is held needs the buffer to take the held one
    a_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && in_valid_reg |-> can_load)
        else $error("input ready while held word cannot move on");

    // a whole-screen scroll always starts at the top row
    a_screen: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == ACT_SCREEN |-> m_tdata[114:108] == 7'd0)
        else $error("screen scroll with non-zero shift top");

    // cursor row stays below MAX_ROWS, the largest screen height
    a_row: assert property (@(posedge aclk) disable iff (!aresetn)
        xfer |=> {1'b0, cursor_reg.row} < 8'(MAX_ROWS))
        else $error("cursor row beyond screen limit");

endmodule

@@ sim/tb.sv @@
// tb: self-checking bench for terminal_cursor_autowrap_top; a cursor and wrap tracker
// kept beside the dut predicts every cell write and scroll word, checked in order
// depends on tca_pkg and the rtl under hw/rtl
module tb;
    import tca_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 6;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [5:0]  pad;
        logic [6:0]  shift_bottom;
        logic [6:0]  shift_top;
        logic [7:0]  attrs;
        logic [31:0] back;
        logic [31:0] fore;
        logic [20:0] code;
        logic [7:0]  col;
        logic [6:0]  row;
    } cell_word_t;

    typedef struct packed {
        action_t    act;
        cell_word_t word;
        logic       last;
    } screen_cmd_t;

    logic         aclk      = 1'b0;
    logic         aresetn   = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata   = '0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [127:0] m_tdata;
    logic [1:0]   m_tuser;
    logic         m_tlast;
    logic         cfg_valid = 1'b0;
    logic         cfg_ready;
    logic [1:0]   cfg_index = CFG_COLUMNS;
    logic [8:0]   cfg_data  = '0;

    // register shadows and cursor tracker
    logic [8:0]        geo_columns = COLUMNS_RESET;
    logic [7:0]        geo_rows    = ROWS_RESET;
    logic [6:0]        geo_top     = TOP_RESET;
    logic signed [7:0] geo_bottom  = BOTTOM_RESET;
    int                cur_row     = 0;
    int                cur_col     = 0;
    bit                wrap_armed  = 1'b0;
    int                step_count;

    screen_cmd_t due_cmds[$];
    int          fail_count  = 0;
    int          cycle_count = 0;
    bit          jitter_on   = 1'b1;

    terminal_cursor_autowrap_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_tready = !jitter_on || ($urandom_range(99) >= 33);
    end

    function automatic int used_cols();
        if (geo_columns == 0) return 1;
        if (geo_columns > MAX_COLS) return MAX_COLS;
        return int'(geo_columns);
    endfunction

    function automatic int used_rows();
        if (geo_rows == 0) return 1;
        if (geo_rows > MAX_ROWS) return MAX_ROWS;
        return int'(geo_rows);
    endfunction

    function automatic void push_cmd(action_t act, int row, int col, logic [20:0] code,
                                     logic [31:0] fore, logic [31:0] back, logic [7:0] attrs,
                                     int stop, int sbot);
        screen_cmd_t c;
        c = '0;
        c.act               = act;
        c.word.row          = 7'(row);
        c.word.col          = 8'(col);
        c.word.code         = code;
        c.word.fore         = fore;
        c.word.back         = back;
        c.word.attrs        = attrs;
        c.word.shift_top    = 7'(stop);
        c.word.shift_bottom = 7'(sbot);
        due_cmds.insert(due_cmds.size(), c);
        step_count++;
    endfunction

    function automatic void feed_line();
        int rows;
        int top;
        int bot;
        rows = used_rows();
        top  = int'(geo_top);
        if (geo_bottom < 0) begin
            bot = rows - 1;
        end else begin
            bot = int'(geo_bottom);
            if (bot > rows - 1) bot = rows - 1;
        end
        // an inverted region falls back to the screen bottom
        if (bot < top) bot = rows - 1;
        cur_row++;
        if (cur_row > bot) begin
            if (top == 0 && bot == rows - 1)
                push_cmd(ACT_SCREEN, 0, 0, '0, '0, '0, '0, 0, rows - 1);
            else
                push_cmd(ACT_REGION, 0, 0, '0, '0, '0, '0, (top < bot) ? top : bot, bot);
            cur_row = bot;
        end
    endfunction

    function automatic void advance_cursor(item_t it);
        int cols;
        int rows;
        int w;
        cols = used_cols();
        rows = used_rows();
        w = (it.width == 2'd3) ? 2 : int'(it.width);
        step_count = 0;
        if (it.code == CP_LF) begin
            cur_col    = 0;
            wrap_armed = 1'b0;
            feed_line();
        end else if (it.code == CP_CR) begin
            cur_col    = 0;
            wrap_armed = 1'b0;
        end else if (it.code == CP_BS) begin
            if (wrap_armed) wrap_armed = 1'b0;
            else if (cur_col > 0) cur_col--;
        end else if (it.code == CP_TAB) begin
            wrap_armed = 1'b0;
            cur_col = (cur_col / TAB_STOP + 1) * TAB_STOP;
            if (cur_col >= cols) cur_col = cols - 1;
        end else if (it.code < CP_SPACE || it.code == CP_DEL) begin
            // remaining controls leave the cursor alone
        end else begin
            if (wrap_armed) begin
                cur_col = 0;
                feed_line();
                wrap_armed = 1'b0;
            end
            if (w != 0) begin
                // a wide glyph may not straddle the right edge
                if (w == 2 && cur_col == cols - 1) begin
                    cur_col = 0;
                    feed_line();
                end
                if (cur_row < rows && cur_col < cols) begin
                    push_cmd(ACT_GLYPH, cur_row, cur_col, it.code, it.fore, it.back,
                             it.attrs, 0, 0);
                    if (w == 2 && cur_col + 1 < cols)
                        push_cmd(ACT_SPACER, cur_row, cur_col + 1, '0, it.fore, it.back,
                                 it.attrs, 0, 0);
                end
                if (cur_col + w >= cols) wrap_armed = 1'b1;
                else cur_col += w;
            end
        end
        if (step_count > 0) due_cmds[due_cmds.size() - 1].last = 1'b1;
    endfunction

    task automatic note_mismatch(string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_field(string name, longint unsigned got, longint unsigned want);
        if (got != want)
            note_mismatch($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    always @(posedge aclk) begin : result_check
        screen_cmd_t want;
        cell_word_t  got;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (due_cmds.size() == 0) begin
                note_mismatch($sformatf("word with nothing pending, action %0d", m_tuser));
            end else begin
                want = due_cmds[0];
                due_cmds.delete(0);
                check_field("action", m_tuser, want.act);
                check_field("last", m_tlast, want.last);
                check_field("cell_row", got.row, want.word.row);
                check_field("cell_col", got.col, want.word.col);
                check_field("cell_code", got.code, want.word.code);
                check_field("cell_fore", got.fore, want.word.fore);
                check_field("cell_back", got.back, want.word.back);
                check_field("cell_attrs", got.attrs, want.word.attrs);
                check_field("shift_top", got.shift_top, want.word.shift_top);
                check_field("shift_bottom", got.shift_bottom, want.word.shift_bottom);
                check_field("tdata fill", got.pad, want.word.pad);
            end
        end
    end

    task automatic send_item(logic [20:0] code, logic [1:0] width, logic [31:0] fore,
                             logic [31:0] back, logic [7:0] attrs);
        item_t it;
        it.code  = code;
        it.width = width;
        it.fore  = fore;
        it.back  = back;
        it.attrs = attrs;
        @(negedge aclk);
        while (jitter_on && $urandom_range(99) < 33) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tdata  = {1'b0, it};
        s_tvalid = 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        advance_cursor(it);
    endtask

    task automatic send_char(logic [20:0] code, logic [1:0] width);
        send_item(code, width, $urandom(), $urandom(), 8'($urandom()));
    endtask

    // wait out every pending word plus the pipeline behind a word with no result
    task automatic go_idle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (due_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(cfg_index_t idx, logic [8:0] val);
        @(negedge aclk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_COLUMNS: geo_columns = val;
            CFG_ROWS:    geo_rows    = val[7:0];
            CFG_TOP:     geo_top     = val[6:0];
            CFG_BOTTOM:  geo_bottom  = val[7:0];
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_geometry(logic [8:0] cols, logic [8:0] rows, logic [8:0] top,
                                logic [8:0] bottom);
        go_idle();
        write_reg(CFG_COLUMNS, cols);
        write_reg(CFG_ROWS, rows);
        write_reg(CFG_TOP, top);
        write_reg(CFG_BOTTOM, bottom);
    endtask

    function automatic logic [20:0] pick_code();
        case ($urandom_range(11))
            0, 1, 2, 3: return 21'($urandom_range(8'h7E, 8'h21));
            4:          return 21'($urandom_range(9'h9F, 8'h80));
            5:          return 21'($urandom_range(21'h10FFFF, 21'hA0));
            6:          return 21'($urandom());
            7, 8:       return CP_LF;
            9:          return ($urandom_range(1) != 0) ? CP_CR : CP_BS;
            10:         return CP_TAB;
            default:    return ($urandom_range(4) == 0) ? CP_DEL : 21'($urandom_range(31));
        endcase
    endfunction

    function automatic logic [1:0] pick_width();
        case ($urandom_range(9))
            0:       return 2'd0;
            1, 2:    return 2'd2;
            3:       return 2'd3;
            default: return 2'd1;
        endcase
    endfunction

    task automatic random_geometry();
        logic [8:0] cols;
        logic [8:0] rows;
        logic [8:0] top;
        logic [8:0] bottom;
        int span;
        case ($urandom_range(5))
            0:       cols = 9'($urandom_range(1));
            1:       cols = 9'($urandom_range(511, 250));
            default: cols = 9'($urandom_range(24, 2));
        endcase
        case ($urandom_range(4))
            0:       rows = 9'($urandom_range(1));
            1:       rows = 9'($urandom_range(255, 120));
            default: rows = 9'($urandom_range(12, 2));
        endcase
        span = (rows > 12) ? 12 : int'(rows);
        top = ($urandom_range(5) == 0) ? 9'($urandom_range(127)) : 9'($urandom_range(span));
        case ($urandom_range(4))
            0:       bottom = 9'h0FF;
            1:       bottom = 9'($urandom_range(255));
            default: bottom = 9'($urandom_range(span + 1));
        endcase
        set_geometry(cols, rows, top, bottom);
    endtask

    // soft wrap, wide wrap, spacers, controls on a tiny screen, after two glyphs on the reset screen
    task automatic test_glyph_wrap();
        send_item(21'h41, 2'd1, 32'h0, 32'hFFFF_FFFF, 8'h00);
        send_item(21'h10FFFF, 2'd2, 32'hFFFF_FFFF, 32'h0, 8'hFF);
        set_geometry(9'd4, 9'd2, 9'd0, 9'h0FF);
        send_char(21'h42, 2'd2);            // wide in the last column wraps first
        send_char(21'h1FFFFF, 2'd3);        // beyond unicode, width three as wide
        send_char(21'h9F, 2'd0);            // pending wrap then dropped zero-width
        send_char(21'h43, 2'd1);
        send_char(CP_TAB, 2'd1);
        send_char(21'h44, 2'd1);
        send_char(CP_BS, 2'd1);
        send_char(CP_BS, 2'd1);
        send_char(21'h00, 2'd1);
        send_char(21'h1F, 2'd1);
        send_char(CP_DEL, 2'd1);
        send_char(CP_CR, 2'd1);
        send_char(CP_LF, 2'd1);
        send_char(21'h80, 2'd1);
    endtask

    task automatic test_scroll_region();
        set_geometry(9'd4, 9'd6, 9'd2, 9'd3);
        repeat (3) send_char(CP_LF, 2'd1);
        set_geometry(9'd4, 9'd6, 9'd2, 9'd1);       // bottom above top
        repeat (3) send_char(CP_LF, 2'd1);
        set_geometry(9'd4, 9'd6, 9'd2, 9'd100);     // bottom past the screen
        send_char(CP_LF, 2'd1);
        set_geometry(9'd4, 9'd6, 9'd2, 9'd3);       // cursor now under the region
        send_char(CP_LF, 2'd1);
        set_geometry(9'd4, 9'd6, 9'd127, 9'h0FF);   // top under the last row
        repeat (3) send_char(CP_LF, 2'd1);
        set_geometry(9'd4, 9'd2, 9'd0, 9'h0FF);     // cursor left off the screen
        send_char(21'h45, 2'd1);
        send_char(CP_LF, 2'd1);
    endtask

    task automatic test_geometry_extremes();
        set_geometry(9'd0, 9'd0, 9'd0, 9'h0FF);
        send_char(CP_LF, 2'd1);
        send_char(21'h46, 2'd1);
        send_char(21'h47, 2'd2);            // no room for a spacer
        send_char(CP_CR, 2'd1);
        send_char(CP_TAB, 2'd1);
        set_geometry(9'd511, 9'd255, 9'd0, 9'h07F);
        repeat (40) send_char(pick_code(), pick_width());
    endtask

    task automatic test_random_traffic();
        repeat (5) begin
            random_geometry();
            repeat (40) send_char(pick_code(), pick_width());
        end
    endtask

    // full rate both ways, with one pause until every word is home
    task automatic test_back_to_back();
        jitter_on = 1'b0;
        random_geometry();
        repeat (30) send_char(pick_code(), pick_width());
        go_idle();
        repeat (30) send_char(pick_code(), pick_width());
        jitter_on = 1'b1;
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_glyph_wrap();
        test_scroll_region();
        test_geometry_extremes();
        test_random_traffic();
        test_back_to_back();
        go_idle();
        if (fail_count == 0 && due_cmds.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
